FILE: src/mgpt_pkg.sv
package mgpt_pkg;

  localparam int TableEntries = 64;
  localparam int GroupFirst = 16;
  localparam int GroupSlots = 32;
  localparam int EntW = $clog2(TableEntries);
  localparam int SlotW = $clog2(GroupSlots);
  localparam int RefW = $clog2(TableEntries + 1);

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NOENT = 2'd1;
  localparam logic [1:0] ST_NOGROUP = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  localparam logic [1:0] CMD_NONE = 2'd0;
  localparam logic [1:0] CMD_INSTALL = 2'd1;
  localparam logic [1:0] CMD_FORGET = 2'd2;

  localparam logic [1:0] KIND_L2 = 2'd0;
  localparam logic [1:0] KIND_V4 = 2'd1;
  localparam logic [1:0] KIND_V6 = 2'd2;

  localparam logic [3:0] CPU_PORT_RESET = 4'd9;

  typedef struct packed {
    logic [1:0] status;
    logic [1:0] mact_cmd;
    logic [47:0] mact_mac;
    logic [11:0] mact_vid;
    logic [1:0] mact_kind;
    logic [6:0] mact_dest;
    logic cpu_mirror;
    logic group_write;
    logic [6:0] group_write_index;
    logic [15:0] group_write_ports;
  } result_t;

  function automatic logic [1:0] classify(input logic [47:0] mac);
    logic [1:0] k;
    k = KIND_L2;
    if (mac[47:23] == {24'h01005E, 1'b0}) k = KIND_V4;
    else if (mac[47:32] == 16'h3333) k = KIND_V6;
    return k;
  endfunction

  function automatic logic [47:0] encode_mac(input logic [47:0] mac, input logic [15:0] p,
                                             input logic [1:0] kind);
    logic [47:0] m;
    m = mac;
    if (kind == KIND_V4) m = {8'h00, p, mac[23:0]};
    else if (kind == KIND_V6) m = {p, mac[31:0]};
    return m;
  endfunction

endpackage

FILE: src/multicast_group_port_table_unit.sv
// channel | direction | handshake            | payload
// in_     | input     | in_valid/in_ready    | req_type group_mac vlan_id port
// out_    | output    | out_valid/out_ready  | status and mac table command
// cfg_    | input     | cfg_we               | cpu_port
// one transaction runs an entry scan (one memory read a cycle plus fill and
// drain), a decide state, then the group scans (L2 groups only) and a commit
// state where the request needs them, before the result is valid.
// reset clears entry valid bits and group refcounts at once.
// the result waits in an output register; the next transaction is taken
// once the result is taken.
module multicast_group_port_table_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_req_type,
  input  logic [47:0] in_group_mac,
  input  logic [11:0] in_vlan_id,
  input  logic [3:0]  in_port,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [1:0]  out_mact_cmd,
  output logic [47:0] out_mact_mac,
  output logic [11:0] out_mact_vid,
  output logic [1:0]  out_mact_kind,
  output logic [6:0]  out_mact_dest,
  output logic        out_cpu_mirror,
  output logic        out_group_write,
  output logic [6:0]  out_group_write_index,
  output logic [15:0] out_group_write_ports
);

  localparam int EW = mgpt_pkg::EntW;
  localparam int SW = mgpt_pkg::SlotW;
  localparam int RW = mgpt_pkg::RefW;
  localparam int NE = mgpt_pkg::TableEntries;
  localparam int NS = mgpt_pkg::GroupSlots;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_SCAN   = 7'b0000010,
    S_DECIDE = 7'b0000100,
    S_GMATCH = 7'b0001000,
    S_GFREE  = 7'b0010000,
    S_COMMIT = 7'b0100000,
    S_OUT    = 7'b1000000
  } state_t;

  state_t state_r;

  logic [3:0] cpu_port_r;
  logic del_r;
  logic [47:0] mac_r;
  logic [11:0] vid_r;
  logic [15:0] pbit_r;
  logic [1:0] kind_r;

  logic [NE-1:0] ent_valid_r;
  logic [47:0] ent_mac_m [NE];
  logic [11:0] ent_vid_m [NE];
  logic [15:0] ent_ports_m [NE];
  logic [SW-1:0] ent_group_m [NE];
  logic [47:0] rd_mac_r;
  logic [11:0] rd_vid_r;
  logic [15:0] rd_ports_r;
  logic [SW-1:0] rd_group_r;

  logic [RW-1:0] refcnt_r [NS];
  logic [15:0] gports_m [NS];

  logic [EW:0] cnt_r;
  logic rd_live_r;
  logic [EW-1:0] rd_idx_r;
  logic found_r, free_ok_r;
  logic [EW-1:0] idx_r, free_r;
  logic [SW-1:0] oldg_r;
  logic [15:0] newp_r;
  logic [15:0] key_r;
  logic [SW:0] scnt_r;
  logic [SW-1:0] slot_r;
  logic fresh_grp_r;
  logic fresh_ent_r;
  logic use_slot_r;
  logic put_old_r;
  logic do_write_r;

  mgpt_pkg::result_t res_r;

  logic in_fire;
  logic [EW-1:0] cnt_idx;
  logic [SW-1:0] sidx;
  logic [15:0] cbit;
  logic [6:0] gidx;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire = in_valid && in_ready;
  assign out_valid = (state_r == S_OUT);
  assign cnt_idx = cnt_r[EW-1:0];
  assign sidx = scnt_r[SW-1:0];
  assign cbit = 16'(1) << cpu_port_r;
  assign gidx = 7'(mgpt_pkg::GroupFirst + int'(slot_r));

  assign out_status = res_r.status;
  assign out_mact_cmd = res_r.mact_cmd;
  assign out_mact_mac = res_r.mact_mac;
  assign out_mact_vid = res_r.mact_vid;
  assign out_mact_kind = res_r.mact_kind;
  assign out_mact_dest = res_r.mact_dest;
  assign out_cpu_mirror = res_r.cpu_mirror;
  assign out_group_write = res_r.group_write;
  assign out_group_write_index = res_r.group_write_index;
  assign out_group_write_ports = res_r.group_write_ports;

  always_ff @(posedge clk) begin
    rd_mac_r <= ent_mac_m[cnt_idx];
    rd_vid_r <= ent_vid_m[cnt_idx];
    if (do_write_r) begin
      if (fresh_ent_r) begin
        ent_mac_m[free_r] <= mac_r;
        ent_vid_m[free_r] <= vid_r;
        ent_ports_m[free_r] <= newp_r;
        ent_group_m[free_r] <= use_slot_r ? slot_r : '0;
      end else begin
        ent_ports_m[idx_r] <= newp_r;
        ent_group_m[idx_r] <= use_slot_r ? slot_r : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_ports_r <= ent_ports_m[idx_r];
    rd_group_r <= ent_group_m[idx_r];
  end

  always_ff @(posedge clk) begin
    if (state_r == S_GFREE && scnt_r < (SW+1)'(NS) && refcnt_r[sidx] == '0) begin
      gports_m[sidx] <= key_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cpu_port_r <= mgpt_pkg::CPU_PORT_RESET;
      ent_valid_r <= '0;
      for (int s = 0; s < NS; s++) refcnt_r[s] <= '0;
      do_write_r <= 1'b0;
      rd_live_r <= 1'b0;
    end else begin
      do_write_r <= 1'b0;
      if (cfg_we) cpu_port_r <= cfg_wdata;
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            state_r <= S_SCAN;
            del_r <= in_req_type;
            mac_r <= in_group_mac;
            vid_r <= in_vlan_id;
            pbit_r <= 16'(1) << in_port;
            kind_r <= mgpt_pkg::classify(in_group_mac);
            cnt_r <= '0;
            rd_live_r <= 1'b0;
            found_r <= 1'b0;
            free_ok_r <= 1'b0;
            res_r <= '0;
          end
        end
        S_SCAN: begin
          if (rd_live_r) begin
            if (ent_valid_r[rd_idx_r]) begin
              if (!found_r && rd_mac_r == mac_r && rd_vid_r == vid_r) begin
                found_r <= 1'b1;
                idx_r <= rd_idx_r;
              end
            end else if (!free_ok_r) begin
              free_ok_r <= 1'b1;
              free_r <= rd_idx_r;
            end
          end
          rd_live_r <= (cnt_r < (EW+1)'(NE));
          rd_idx_r <= cnt_idx;
          if (cnt_r < (EW+1)'(NE)) cnt_r <= cnt_r + 1'b1;
          if (cnt_r == (EW+1)'(NE) && !rd_live_r) state_r <= S_DECIDE;
        end
        S_DECIDE: begin
          // rd_ports_r / rd_group_r now hold the found entry
          oldg_r <= rd_group_r;
          fresh_ent_r <= !found_r;
          fresh_grp_r <= 1'b0;
          use_slot_r <= 1'b0;
          put_old_r <= 1'b0;
          scnt_r <= '0;
          state_r <= S_OUT;
          if (!del_r) begin
            if (!found_r && !free_ok_r) begin
              res_r.status <= mgpt_pkg::ST_FULL;
            end else if (found_r && (rd_ports_r & pbit_r) != '0) begin
              res_r <= '0;
            end else begin
              newp_r <= (found_r ? rd_ports_r : 16'h0) | pbit_r;
              key_r <= ((found_r ? rd_ports_r : 16'h0) | pbit_r) & ~cbit;
              put_old_r <= found_r && kind_r == mgpt_pkg::KIND_L2;
              state_r <= (kind_r == mgpt_pkg::KIND_L2) ? S_GMATCH : S_COMMIT;
            end
          end else begin
            if (!found_r) begin
              res_r.status <= mgpt_pkg::ST_NOENT;
            end else if ((rd_ports_r & pbit_r) == '0) begin
              res_r <= '0;
            end else if ((rd_ports_r & ~pbit_r) == '0) begin
              res_r.mact_cmd <= mgpt_pkg::CMD_FORGET;
              res_r.mact_mac <= mac_r;
              res_r.mact_vid <= vid_r;
              res_r.mact_kind <= kind_r;
              ent_valid_r[idx_r] <= 1'b0;
              if (kind_r == mgpt_pkg::KIND_L2 && refcnt_r[rd_group_r] != '0)
                refcnt_r[rd_group_r] <= refcnt_r[rd_group_r] - 1'b1;
            end else begin
              newp_r <= rd_ports_r & ~pbit_r;
              key_r <= rd_ports_r & ~pbit_r & ~cbit;
              put_old_r <= kind_r == mgpt_pkg::KIND_L2;
              state_r <= (kind_r == mgpt_pkg::KIND_L2) ? S_GMATCH : S_COMMIT;
            end
          end
        end
        S_GMATCH: begin
          if (scnt_r == (SW+1)'(NS)) begin
            scnt_r <= '0;
            state_r <= S_GFREE;
          end else if (refcnt_r[sidx] != '0 && gports_m[sidx] == key_r) begin
            slot_r <= sidx;
            use_slot_r <= 1'b1;
            state_r <= S_COMMIT;
          end else begin
            scnt_r <= scnt_r + 1'b1;
          end
        end
        S_GFREE: begin
          if (scnt_r == (SW+1)'(NS)) begin
            res_r.status <= mgpt_pkg::ST_NOGROUP;
            state_r <= S_OUT;
          end else if (refcnt_r[sidx] == '0) begin
            slot_r <= sidx;
            use_slot_r <= 1'b1;
            fresh_grp_r <= 1'b1;
            state_r <= S_COMMIT;
          end else begin
            scnt_r <= scnt_r + 1'b1;
          end
        end
        S_COMMIT: begin
          state_r <= S_OUT;
          res_r.mact_cmd <= mgpt_pkg::CMD_INSTALL;
          res_r.mact_mac <= mgpt_pkg::encode_mac(mac_r, newp_r, kind_r);
          res_r.mact_vid <= vid_r;
          res_r.mact_kind <= kind_r;
          res_r.mact_dest <= use_slot_r ? gidx : 7'd0;
          res_r.cpu_mirror <= (newp_r & cbit) != '0;
          res_r.group_write <= fresh_grp_r;
          res_r.group_write_index <= fresh_grp_r ? gidx : 7'd0;
          res_r.group_write_ports <= fresh_grp_r ? key_r : 16'd0;
          do_write_r <= 1'b1;
          if (fresh_ent_r) ent_valid_r[free_r] <= 1'b1;
          if (use_slot_r) begin
            if (put_old_r && oldg_r == slot_r) begin
              refcnt_r[slot_r] <= refcnt_r[slot_r];
            end else begin
              refcnt_r[slot_r] <= fresh_grp_r ? RW'(1) : refcnt_r[slot_r] + 1'b1;
              if (put_old_r && refcnt_r[oldg_r] != '0)
                refcnt_r[oldg_r] <= refcnt_r[oldg_r] - 1'b1;
            end
          end
        end
        S_OUT: begin
          if (out_ready) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
